[sv/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared constants, types and the rotate function for the sha-512 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

   localparam int unsigned WordWidth  = 64;
   localparam int unsigned BlockBytes = 128;
   localparam int unsigned Rounds     = 80;
   localparam int unsigned LenByte    = 112;

   localparam logic [7:0] PadMarker = 8'h80;

   // operation codes
   localparam logic OpAbsorb = 1'b0;
   localparam logic OpFinish = 1'b1;

   typedef logic [WordWidth-1:0] word_type;

   localparam word_type InitHash [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   localparam word_type RoundConst [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   function automatic word_type ror64(word_type x, int unsigned n);
      ror64 = (x >> n) | (x << (WordWidth - n));
   endfunction

   // control from the sequencer to the round unit
   typedef struct packed {
      logic       start;
      logic       load;
      logic [6:0] round;
   } round_ctl_type;

endpackage

[sv/sha512_round.sv]
// ----------------------------------------------------------------------------
// sha512_round
// Shared compression round unit: one round per cycle, schedule window
// in a 16-entry shift line, working variables folded into the hash at end.
// ----------------------------------------------------------------------------
module sha512_round
   import sha512_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  logic [7:0]    byte_in,
   input  logic          byte_shift,
   input  logic          restart,
   input  logic          finish_round,
   output word_type      hash_out [8]
);

   word_type hash_ff [8];
   word_type var_ff  [8];
   word_type w_ff    [16];

   word_type wt, s0, s1, t1, t2, e, a;

   // message word for this round
   always_comb begin
      s1 = ror64(w_ff[14], 19) ^ ror64(w_ff[14], 61) ^ (w_ff[14] >> 6);
      s0 = ror64(w_ff[1], 1) ^ ror64(w_ff[1], 8) ^ (w_ff[1] >> 7);
      if (ctl.round < 7'd16) begin
         wt = w_ff[0];
      end else begin
         wt = s1 + w_ff[9] + s0 + w_ff[0];
      end
      e  = var_ff[4];
      a  = var_ff[0];
      t1 = var_ff[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
           + ((e & var_ff[5]) ^ (~e & var_ff[6])) + RoundConst[ctl.round] + wt;
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
           + ((a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // schedule window: bytes shift in, rounds rotate it
   always_ff @(posedge clock) begin
      if (byte_shift) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= {w_ff[i][55:0], w_ff[i+1][63:56]};
         end
         w_ff[15] <= {w_ff[15][55:0], byte_in};
      end else if (ctl.start) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= wt;
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         var_ff <= hash_ff;
      end else if (ctl.start) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         hash_ff <= InitHash;
      end else if (finish_round) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + var_ff[i];
         end
      end
   end

   assign hash_out = hash_ff;

endmodule

[sv/sha512_hash_engine_top.sv]
// ----------------------------------------------------------------------------
// sha512_hash_engine_top
// SHA-512 engine taking one message byte per word.
// ----------------------------------------------------------------------------
// An absorb word shifts its byte into the schedule window; the 128th byte
// of a block leads to a load state, the 80 rounds of the single shared
// round unit and a fold state. A finish word streams the padding one byte per cycle
// through the same path (one or two blocks), then gives eight digest words,
// H0 first, with rsp_digest_last on H7. req_ready is low while busy.
module sha512_hash_engine_top
   import sha512_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [6:0]    idx_ff, idx_in;
   logic [60:0]   count_ff, count_in;
   logic [6:0]    round_ff, round_in;
   logic          fin_ff, fin_in;
   logic [2:0]    out_ff, out_in;
   logic          mark_ff, mark_in;
   logic [63:0]   bits;
   logic [7:0]    pad_byte;
   logic          shift;
   logic [7:0]    byte_sel;
   round_ctl_type ctl;
   word_type      hash [8];
   logic          restart;

   assign bits = {count_ff, 3'b000};

   // padding byte: marker, zeros, then length big-endian
   always_comb begin
      if (!mark_ff) begin
         pad_byte = PadMarker;
      end else if (fin_ff && idx_ff >= 7'd120) begin
         pad_byte = bits[8*(7 - {29'd0, idx_ff[2:0]}) +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign shift = (req_valid && req_ready && req_operation == OpAbsorb)
                  || (state_ff == ST_PAD);
   assign byte_sel = (state_ff == ST_PAD) ? pad_byte : req_data_byte;
   assign restart = (state_ff == ST_OUT) && rsp_ready && out_ff == 3'd7;

   assign ctl.load  = (state_ff == ST_LOAD);
   assign ctl.start = (state_ff == ST_ROUND);
   assign ctl.round = round_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      round_in = round_ff;
      fin_in   = fin_ff;
      out_in   = out_ff;
      mark_in  = mark_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OpAbsorb) begin
                  idx_in   = idx_ff + 7'd1;
                  count_in = count_ff + 61'd1;
                  if (idx_ff == 7'd127) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  mark_in  = 1'b0;
                  fin_in   = (idx_ff < 7'd112);
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            mark_in = 1'b1;
            idx_in  = idx_ff + 7'd1;
            if (!fin_ff && idx_ff == 7'd127) begin
               state_in = ST_LOAD;
            end else if (fin_ff && idx_ff == 7'd127) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            round_in = 7'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(Rounds - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!mark_ff) begin
               state_in = ST_IDLE;
            end else if (fin_ff) begin
               out_in   = 3'd0;
               state_in = ST_OUT;
            end else begin
               fin_in   = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  idx_in   = 7'd0;
                  count_in = 61'd0;
                  mark_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 7'd0;
         count_ff <= 61'd0;
         mark_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      out_ff   <= out_in;
   end

   sha512_round u_round (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .byte_in      (byte_sel),
      .byte_shift   (shift),
      .restart      (restart),
      .finish_round (state_ff == ST_FOLD),
      .hash_out     (hash)
   );

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash[out_ff];
   assign rsp_digest_last = (out_ff == 3'd7);

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !req_ready) else $error("ready during rounds");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 7'd79) |=> (state_ff == ST_FOLD))
      else $error("round count slip");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> (state_ff == ST_IDLE && idx_ff == 7'd0))
      else $error("no return to idle");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sha-512 engine: byte words and finish words go
// in, digest words come out and are compared with a local sha-512 predictor.
// ----------------------------------------------------------------------------
module tb;
   import sha512_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OpAbsorb;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest_word;
   logic        rsp_digest_last;

   sha512_hash_engine_top dut (.*);

   always #1 clock = ~clock;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } digest_entry_type;

   // predictor state
   word_type    chain [8];
   logic [7:0]  blk [128];
   logic [6:0]  fill;
   logic [60:0] msg_len;

   digest_entry_type digest_q [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   bit timed_out = 0;

   // directed rows: op, byte, first expected word (0 = use predictor only)
   typedef struct {
      logic       op;
      logic [7:0] data;
      logic [63:0] h0;
   } row_type;

   row_type rows [$];

   function automatic word_type rot(word_type x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void compress();
      word_type w [16];
      word_type v [8];
      word_type t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) begin
         w[t] = '0;
         for (int i = 0; i < 8; i++) w[t] = (w[t] << 8) | word_type'(blk[t*8+i]);
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            s1 = rot(w[(t-2)&15], 19) ^ rot(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
            s0 = rot(w[(t-15)&15], 1) ^ rot(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
            w[t&15] = s1 + w[(t-7)&15] + s0 + w[t&15];
         end
         t1 = v[7] + (rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t&15];
         t2 = (rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   function automatic void push_byte(logic [7:0] b);
      blk[fill] = b;
      fill = fill + 7'd1;
      if (fill == 7'd0) compress();
   endfunction

   // predict the effect of one accepted word
   function automatic void hash_word(logic op, logic [7:0] data);
      logic [63:0] bits;
      digest_entry_type e;
      if (op == OpAbsorb) begin
         push_byte(data);
         msg_len = msg_len + 61'd1;
         return;
      end
      bits = {msg_len, 3'b000};
      push_byte(PadMarker);
      while (fill != 7'(LenByte)) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(8'h00);
      for (int i = 7; i >= 0; i--) push_byte(bits[i*8 +: 8]);
      for (int i = 0; i < 8; i++) begin
         e.word = chain[i];
         e.last = (i == 7);
         digest_q.push_back(e);
      end
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      fill = '0;
      msg_len = '0;
   endfunction

   // send one word and wait for its acceptance; valid drops only on idle cycles
   task automatic send_word(logic op, logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      hash_word(op, data);
      @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   // digest checking
   always @(posedge clock) begin
      digest_entry_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected digest word %h", rsp_digest_word);
         end else begin
            e = digest_q.pop_front();
            if (e.word !== rsp_digest_word || e.last !== rsp_digest_last) begin
               errors++;
               if (errors <= 10)
                  $display("digest mismatch: exp %h/%b got %h/%b", e.word, e.last,
                           rsp_digest_word, rsp_digest_last);
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one random message of a few bytes
   task automatic random_message();
      int len;
      case ($urandom_range(3))
         0: len = $urandom_range(8);
         default: len = $urandom_range(12);
      endcase
      for (int i = 0; i < len; i++) send_word(OpAbsorb, 8'($urandom));
      send_word(OpFinish, 8'($urandom));
   endtask

   initial begin
      row_type r;
      logic [63:0] first;
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      fill = '0;
      msg_len = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty message (data ignored on finish), then "abc", then four bytes (predictor only)
      rows.push_back('{OpFinish, 8'hff, 64'hcf83e1357eefb8bd});
      rows.push_back('{OpAbsorb, 8'h61, 64'h0});
      rows.push_back('{OpAbsorb, 8'h62, 64'h0});
      rows.push_back('{OpAbsorb, 8'h63, 64'h0});
      rows.push_back('{OpFinish, 8'h00, 64'hddaf35a193617aba});
      rows.push_back('{OpAbsorb, 8'h00, 64'h0});
      rows.push_back('{OpAbsorb, 8'hff, 64'h0});
      rows.push_back('{OpAbsorb, 8'h55, 64'h0});
      rows.push_back('{OpAbsorb, 8'haa, 64'h0});
      rows.push_back('{OpFinish, 8'h5a, 64'h0});
      foreach (rows[i]) begin
         r = rows[i];
         send_word(r.op, r.data);
         if (r.op == OpFinish && r.h0 != 64'h0) begin
            first = digest_q[digest_q.size() - 8].word;
            if (first !== r.h0) begin
               errors++;
               $display("known digest wrong: exp %h pred %h", r.h0, first);
            end
         end
      end
      // marker at byte 112 pushes the length into a second block
      for (int i = 0; i < 112; i++) send_word(OpAbsorb, 8'($urandom));
      send_word(OpFinish, 8'h00);

      // random traffic through the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 22 : 55) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 22 : 55) : 0;
         for (int m = 0; m < 3; m++) random_message();
         // hold off until every digest word is back
         req_valid <= 1'b0;
         while (digest_q.size() != 0) @(negedge clock);
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (digest_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && digest_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/sha512_pkg.sv
sv/sha512_round.sv
sv/sha512_hash_engine_top.sv
bench/tb.sv
